// ===== design/wels_pkg.sv =====
// package for the windowed edge level stepper
// holds sizes, payload structs and register addresses used by every design file
// no dependencies
package wels_pkg;

  // window and level sizes
  localparam int WINDOW_DEPTH = 64;
  localparam int LEVEL_COUNT  = 4;

  // field widths
  localparam int SAMPLE_W = 16;
  localparam int RAW_W    = 17;
  localparam int LVL_IN_W = 4;
  localparam int LEVEL_W  = 3;
  localparam int FILL_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW_DEPTH);
  localparam int CNT_W    = $clog2(WINDOW_DEPTH);

  // divider step counter width
  localparam int DIV_STEP_W = $clog2(SUM_W);

  // Q1.15 full scale
  localparam logic [SAMPLE_W-1:0] ONE_Q15 = SAMPLE_W'(32768);

  // register map, index taken from byte address bit 2
  localparam int ADDR_W = 3;
  localparam logic REG_LOW_THR  = 1'b0;
  localparam logic REG_HIGH_THR = 1'b1;

  // register reset values
  localparam logic [SAMPLE_W-1:0] LOW_THR_RST  = SAMPLE_W'(983);
  localparam logic [SAMPLE_W-1:0] HIGH_THR_RST = SAMPLE_W'(3277);

  typedef struct packed {
    logic signed [RAW_W-1:0]    sample;
    logic signed [LVL_IN_W-1:0] current_level;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [SAMPLE_W-1:0] peak;
    logic [FILL_W-1:0]   fill_count;
    logic [LEVEL_W-1:0]  suggested_level;
  } out_t;

endpackage

// ===== design/wels_cell.sv =====
// one window cell: holds a stored sample and a running peak
// the sample shifts to the next cell on a push, the peak moves on every cycle
// depends on wels_pkg
module wels_cell
  import wels_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  logic [SAMPLE_W-1:0] sample_in,
  input  logic [SAMPLE_W-1:0] max_in,
  output logic [SAMPLE_W-1:0] sample_out,
  output logic [SAMPLE_W-1:0] max_out
);

  logic [SAMPLE_W-1:0] sample_r;
  logic [SAMPLE_W-1:0] max_r;
  logic [SAMPLE_W-1:0] max_nxt;

  // peak of everything upstream including this cell
  assign max_nxt = (sample_r > max_in) ? sample_r : max_in;

  // storage and peak wave
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r <= '0;
      max_r    <= '0;
    end else begin
      if (shift_en) begin
        sample_r <= sample_in;
      end
      max_r <= max_nxt;
    end
  end

  assign sample_out = sample_r;
  assign max_out    = max_r;

endmodule

// ===== design/wels_div.sv =====
// restoring divider, one quotient bit per cycle
// divides the window sum by the fill count into a SUM_W-bit quotient
// depends on wels_pkg
module wels_div
  import wels_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  dividend,
  input  logic [FILL_W-1:0] divisor,
  output logic [SUM_W-1:0]  quotient,
  output logic              done
);

  logic                  busy_r;
  logic                  done_r;
  logic [DIV_STEP_W-1:0] step_r;
  logic [SUM_W-1:0]      dvd_r;
  logic [SUM_W-1:0]      quo_r;
  logic [FILL_W-1:0]     rem_r;
  logic [FILL_W-1:0]     div_r;
  logic [FILL_W:0]       trial;
  logic                  fits;
  logic [FILL_W-1:0]     rem_nxt;

  // trial subtract of the next remainder
  assign trial   = {rem_r, dvd_r[SUM_W-1]};
  assign fits    = (trial >= {1'b0, div_r});
  assign rem_nxt = fits ? FILL_W'(trial - {1'b0, div_r}) : FILL_W'(trial);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      step_r <= '0;
    end else if (busy_r) begin
      if (step_r == DIV_STEP_W'(SUM_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end else begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      div_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[SUM_W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// ===== design/windowed_edge_level_stepper.sv =====
// top level of the windowed edge level stepper
// uses wels_pkg, a row of wels_cell and one wels_div
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one edge-fraction sample in Q1.15
//   and the current quality level. The sample is clamped to 0..1.0 and pushed
//   into a 64-entry window built as a shift row of cells.
//   out channel (out_valid/out_ready/out_data): window average, peak, fill
//   count and suggested level, one result per input transfer.
//   APB port: low_threshold at address 0, high_threshold at address 4; write
//   only while no item is in flight. pready is tied high.
// Timing:
//   a result follows its input transfer through the peak scan and the final
//   state. The peak travels one cell per cycle along the 64-cell row, which
//   sets the latency; the 22-step divider runs in the shadow of that scan.
//   in_ready returns with the result, so no new item is taken until then.
// Reset:
//   rst_n clears the window, sum, fill count and scan counter at once and restores
//   the threshold registers; no clearing pass is needed.
// Stall:
//   the result waits in an output register; the next item is still accepted
//   and processed, and its result holds inside until out_ready frees the slot.
module windowed_edge_level_stepper
  import wels_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_t              out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic                out_valid_r;
  out_t                out_data_r;
  logic [LEVEL_W-1:0]  cur_r;
  logic [SUM_W-1:0]    sum_r;
  logic [SUM_W-1:0]    sum_nxt;
  logic [FILL_W-1:0]   filled_r;
  logic [FILL_W-1:0]   filled_nxt;
  logic [SAMPLE_W-1:0] low_thr_r;
  logic [SAMPLE_W-1:0] high_thr_r;

  logic                accept;
  logic                out_free;
  logic [SAMPLE_W-1:0] sample_clamped;
  logic [LEVEL_W-1:0]  level_clamped;
  logic [SAMPLE_W-1:0] sample_w [WINDOW_DEPTH];
  logic [SAMPLE_W-1:0] max_w    [WINDOW_DEPTH];
  logic [SUM_W-1:0]    quotient;
  logic                div_done;
  logic [SAMPLE_W-1:0] avg;
  logic [LEVEL_W-1:0]  sug;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // input clamping
  always_comb begin
    if (in_data.sample[RAW_W-1]) begin
      sample_clamped = '0;
    end else if (in_data.sample[RAW_W-2:0] > ONE_Q15) begin
      sample_clamped = ONE_Q15;
    end else begin
      sample_clamped = in_data.sample[SAMPLE_W-1:0];
    end
    if (in_data.current_level[LVL_IN_W-1]) begin
      level_clamped = '0;
    end else if (in_data.current_level[LVL_IN_W-2:0] > (LVL_IN_W-1)'(LEVEL_COUNT - 1)) begin
      level_clamped = LEVEL_W'(LEVEL_COUNT - 1);
    end else begin
      level_clamped = LEVEL_W'(in_data.current_level[LVL_IN_W-2:0]);
    end
  end

  // running sum drops the sample that falls off the end of the row
  assign sum_nxt = sum_r - SUM_W'(sample_w[WINDOW_DEPTH-1]) + SUM_W'(sample_clamped);
  assign filled_nxt = (filled_r < FILL_W'(WINDOW_DEPTH)) ? filled_r + 1'b1 : filled_r;

  // window row
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      wels_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (accept),
        .sample_in  (sample_clamped),
        .max_in     ('0),
        .sample_out (sample_w[k]),
        .max_out    (max_w[k])
      );
    end else begin : g_body
      wels_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .shift_en   (accept),
        .sample_in  (sample_w[k-1]),
        .max_in     (max_w[k-1]),
        .sample_out (sample_w[k]),
        .max_out    (max_w[k])
      );
    end
  end

  // average divider
  wels_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .dividend (sum_nxt),
    .divisor  (filled_nxt),
    .quotient (quotient),
    .done     (div_done)
  );

  assign avg = quotient[SAMPLE_W-1:0];

  // hysteresis step once the window is half full, down wins when both thresholds are crossed
  always_comb begin
    sug = cur_r;
    if (filled_r >= FILL_W'(WINDOW_DEPTH / 2)) begin
      if (avg < low_thr_r && cur_r != '0) begin
        sug = cur_r - 1'b1;
      end else if (avg > high_thr_r && cur_r < LEVEL_W'(LEVEL_COUNT - 1)) begin
        sug = cur_r + 1'b1;
      end
    end
  end

  // sequencer, window bookkeeping and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      filled_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            sum_r    <= sum_nxt;
            filled_r <= filled_nxt;
            cur_r    <= level_clamped;
            count_r  <= '0;
            state_r  <= ST_SCAN;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (count_r == CNT_W'(WINDOW_DEPTH - 1)) begin
            state_r <= ST_FIN;
          end else begin
            count_r <= count_r + 1'b1;
          end
          if (out_ready) begin
            out_valid_r <= 1'b0;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            out_data_r.average         <= avg;
            out_data_r.peak            <= max_w[WINDOW_DEPTH-1];
            out_data_r.fill_count      <= filled_r;
            out_data_r.suggested_level <= sug;
            out_valid_r                <= 1'b1;
            state_r                    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= LOW_THR_RST;
      high_thr_r <= HIGH_THR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_LOW_THR:  low_thr_r  <= pwdata[SAMPLE_W-1:0];
        REG_HIGH_THR: high_thr_r <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (paddr[2])
      REG_LOW_THR:  prdata = 32'(low_thr_r);
      REG_HIGH_THR: prdata = 32'(high_thr_r);
      default:      prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // a new result only comes out of the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_FIN))
    else $error("result registered outside the final state");

  // the divider has finished before the result is taken
  a_div_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> div_done)
    else $error("divider still busy at the end of the peak scan");

  // average never exceeds the peak of the same window
  a_avg_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.average <= out_data_r.peak))
    else $error("average above peak");

  // a result always covers at least one and at most a full window
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.fill_count != '0 &&
                     out_data_r.fill_count <= FILL_W'(WINDOW_DEPTH)))
    else $error("fill count out of range");

endmodule

// ===== tb/windowed_edge_level_stepper_test.sv =====
// testbench for the windowed edge level stepper: one predictor of the window,
// a stimulus process, a result sink and a checker; uses wels_pkg and the block
// in design/windowed_edge_level_stepper.sv
`timescale 1ns / 100ps

module windowed_edge_level_stepper_test;
  import wels_pkg::*;

  // register addresses, one word per register
  localparam logic [ADDR_W-1:0] LOW_THR_ADDR  = {REG_LOW_THR, 2'b00};
  localparam logic [ADDR_W-1:0] HIGH_THR_ADDR = {REG_HIGH_THR, 2'b00};
  localparam int MAX_GAP      = 15;
  localparam int LONG_HOLD    = 600;
  localparam int SETTLE_CYCLES = 70;
  localparam int PHASE_ITEMS  = 55;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  in_t               in_data = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  out_t              out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // predictor copy of the window and the thresholds
  logic [SAMPLE_W-1:0] win_store [WINDOW_DEPTH];
  int                  win_wr_ptr;
  int                  win_fill;
  logic [SUM_W-1:0]    win_sum;
  logic [SAMPLE_W-1:0] low_thr_copy;
  logic [SAMPLE_W-1:0] high_thr_copy;

  out_t pending_results [$];

  // run control shared by the stimulus and the sink
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int hold_len = 0;
  int err_count = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_settings = 1;
  int n_holds = 0;

  windowed_edge_level_stepper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("Some tests failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= 50) begin
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    end
  endtask

  // push one sample into the window copy and work out the result it causes
  function automatic out_t predict_window(input in_t item);
    out_t                res;
    logic [SAMPLE_W-1:0] smp;
    int                  lvl;
    int                  avg;
    int                  top;
    if (item.sample[RAW_W-1]) begin
      smp = '0;
    end else if (item.sample[SAMPLE_W-1:0] > ONE_Q15) begin
      smp = ONE_Q15;
    end else begin
      smp = item.sample[SAMPLE_W-1:0];
    end
    if (item.current_level[LVL_IN_W-1]) begin
      lvl = 0;
    end else if (int'(item.current_level[LVL_IN_W-2:0]) > LEVEL_COUNT - 1) begin
      lvl = LEVEL_COUNT - 1;
    end else begin
      lvl = int'(item.current_level[LVL_IN_W-2:0]);
    end
    // ring push with running sum
    win_sum = win_sum - SUM_W'(win_store[win_wr_ptr]) + SUM_W'(smp);
    win_store[win_wr_ptr] = smp;
    win_wr_ptr = (win_wr_ptr + 1) % WINDOW_DEPTH;
    if (win_fill < WINDOW_DEPTH) win_fill++;
    avg = int'(win_sum) / win_fill;
    // peak over the filled entries
    top = 0;
    for (int i = 0; i < win_fill; i++) begin
      if (int'(win_store[i]) > top) top = int'(win_store[i]);
    end
    // hysteresis step once half full, step down wins
    if (win_fill >= WINDOW_DEPTH / 2) begin
      if (avg < int'(low_thr_copy) && lvl > 0) begin
        lvl--;
      end else if (avg > int'(high_thr_copy) && lvl < LEVEL_COUNT - 1) begin
        lvl++;
      end
    end
    res.average         = SAMPLE_W'(avg);
    res.peak            = SAMPLE_W'(top);
    res.fill_count      = FILL_W'(win_fill);
    res.suggested_level = LEVEL_W'(lvl);
    return res;
  endfunction

  // offer one item, after a random gap when tx_idle is set, hold it until the transfer
  task automatic send_item(input in_t item);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(predict_window(item));
    n_sent++;
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == LOW_THR_ADDR) begin
      low_thr_copy = value;
    end else if (addr == HIGH_THR_ADDR) begin
      high_thr_copy = value;
    end
  endtask

  task automatic check_register(input logic [ADDR_W-1:0] addr, input logic [SAMPLE_W-1:0] want,
                                input string name);
    logic [31:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got[SAMPLE_W-1:0] !== want) report_mismatch(name, int'(got[SAMPLE_W-1:0]), int'(want));
  endtask

  task automatic set_thresholds(input int low, input int high);
    apb_write(LOW_THR_ADDR, SAMPLE_W'(low));
    apb_write(HIGH_THR_ADDR, SAMPLE_W'(high));
    check_register(LOW_THR_ADDR, low_thr_copy, "low threshold readback");
    check_register(HIGH_THR_ADDR, high_thr_copy, "high threshold readback");
    n_settings++;
  endtask

  function automatic int edge_sample(input int k);
    case (k)
      0: return -65536;
      1: return -1;
      2: return 0;
      3: return 1;
      4: return 32767;
      5: return 32768;
      6: return 32769;
      default: return 65535;
    endcase
  endfunction

  // sample near a center, now and then any 17-bit pattern
  function automatic in_t draw_item(input int center, input int spread);
    in_t it;
    int  s;
    if ($urandom_range(0, 9) == 0) begin
      it.sample = RAW_W'($urandom);
    end else begin
      s = center - spread + int'($urandom_range(0, 2 * spread));
      it.sample = RAW_W'(s);
    end
    it.current_level = LVL_IN_W'($urandom);
    return it;
  endfunction

  // reset values of both registers
  task automatic test_reset_registers;
    check_register(LOW_THR_ADDR, LOW_THR_RST, "low threshold reset");
    check_register(HIGH_THR_ADDR, HIGH_THR_RST, "high threshold reset");
  endtask

  // edge and out-of-range samples and levels while the window is under half full
  task automatic test_field_extremes;
    in_t it;
    for (int i = 0; i < 24; i++) begin
      it.sample        = RAW_W'(edge_sample(i % 8));
      it.current_level = LVL_IN_W'((i % 16) - 8);
      send_item(it);
    end
    drain();
  endtask

  // several threshold settings, extremes and overlapping ones included
  task automatic test_threshold_sweep;
    int low;
    int high;
    int center;
    int spread;
    for (int ph = 0; ph < 8; ph++) begin
      spread = 2000;
      case (ph)
        0: begin low = int'(LOW_THR_RST); high = int'(HIGH_THR_RST); center = 2000; end
        1: begin low = 0;     high = 32768; center = 16000; spread = 16000; end
        2: begin low = 32768; high = 32768; center = 28000; spread = 6000; end
        3: begin low = 0;     high = 0;     center = 1000;  spread = 1500; end
        4: begin low = 32768; high = 0;     center = 16000; spread = 16000; end
        default: begin
          center = $urandom_range(0, 20000);
          spread = 500 + $urandom_range(0, 3000);
          low    = center - int'($urandom_range(0, 1500));
          high   = center + int'($urandom_range(0, 1500)) - 300;
          if (low < 0) low = 0;
          if (high < 0) high = 0;
        end
      endcase
      if (ph != 0) set_thresholds(low, high);
      tx_idle = (ph % 3) != 2;
      rx_idle = (ph % 4) != 3;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(draw_item(center, spread));
      drain();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // long output hold while items keep coming, so the input stalls
  task automatic test_output_hold;
    tx_idle  = 1'b0;
    hold_len = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_item(draw_item(3000, 3000));
    drain();
    tx_idle = 1'b1;
  endtask

  // no idling on either side
  task automatic test_back_to_back;
    set_thresholds(2500, 6000);
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    for (int i = 0; i < 70; i++) send_item(draw_item(4000, 4000));
    drain();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // result sink: random stalls while rx_idle is set, plus a long hold on request
  initial begin : result_sink
    int stall;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_len > 0) begin
        out_ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        n_holds++;
      end
      stall = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid && hold_len == 0);
    end
  end

  // compare each result transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        n_checked++;
        if (out_data.average !== want.average)
          report_mismatch("average", int'(out_data.average), int'(want.average));
        if (out_data.peak !== want.peak)
          report_mismatch("peak", int'(out_data.peak), int'(want.peak));
        if (out_data.fill_count !== want.fill_count)
          report_mismatch("fill count", int'(out_data.fill_count), int'(want.fill_count));
        if (out_data.suggested_level !== want.suggested_level)
          report_mismatch("suggested level", int'(out_data.suggested_level),
                          int'(want.suggested_level));
      end
    end
  end

  // main sequence
  initial begin
    for (int i = 0; i < WINDOW_DEPTH; i++) win_store[i] = '0;
    win_wr_ptr    = 0;
    win_fill      = 0;
    win_sum       = '0;
    low_thr_copy  = LOW_THR_RST;
    high_thr_copy = HIGH_THR_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_registers();
    test_field_extremes();
    test_threshold_sweep();
    test_output_hold();
    test_back_to_back();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) report_mismatch("results left over", pending_results.size(), 0);
    $display("covered %0d samples and %0d results over %0d threshold settings", n_sent,
             n_checked, n_settings);
    $display("field extremes, overlapping thresholds, %0d long output hold(s), back-to-back flow",
             n_holds);
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
